// ----- src/spq_pkg.sv -----
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, operation and status codes, and the request, response and cell
// control types that the sorted priority queue shares between its files.
// ---------------------------------------------------------------------------
package spq_pkg;

  // Queue geometry.
  localparam int CAPACITY   = 16;
  localparam int KEY_BITS   = 16;
  localparam int TAG_BITS   = 16;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  // Field widths of the channels.
  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 2;

  // Operation codes. The fourth code is unused and leaves the queue as it is.
  localparam logic [OP_BITS-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_POP   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

  // Status codes.
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_BITS-1:0]  operation;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } req_t;

  typedef struct packed {
    logic                   popped_valid;
    logic [KEY_BITS-1:0]    popped_key;
    logic [TAG_BITS-1:0]    popped_tag;
    logic [STATUS_BITS-1:0] status;
    logic [COUNT_BITS-1:0]  entry_count;
  } rsp_t;

  // Broadcast from the queue control to every cell of the chain.
  typedef struct packed {
    logic                push;
    logic                pop;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } cell_ctrl_t;

endpackage

// ----- src/spq_req_if.sv -----
// ---------------------------------------------------------------------------
// Sorted priority queue request channel
// Valid and ready handshake that carries one operation request.
// ---------------------------------------------------------------------------
interface spq_req_if import spq_pkg::*; ();

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ----- src/spq_rsp_if.sv -----
// ---------------------------------------------------------------------------
// Sorted priority queue response channel
// Valid and ready handshake that carries one result per request.
// ---------------------------------------------------------------------------
interface spq_rsp_if import spq_pkg::*; ();

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ----- src/spq_cell.sv -----
// ---------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain. On a push it keeps its entry, takes the new
// entry, or takes its left neighbor's; on a pop it takes its right neighbor's.
// ---------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
  input  logic                clk,
  input  cell_ctrl_t          ctrl,
  input  logic                occupied,
  input  logic                left_lt,
  input  logic [KEY_BITS-1:0] left_key,
  input  logic [TAG_BITS-1:0] left_tag,
  input  logic [KEY_BITS-1:0] right_key,
  input  logic [TAG_BITS-1:0] right_tag,
  output logic                lt,
  output logic [KEY_BITS-1:0] key,
  output logic [TAG_BITS-1:0] tag
);

  logic [KEY_BITS-1:0] key_next;
  logic [TAG_BITS-1:0] tag_next;

  // A held entry strictly below the new key stays ahead of it.
  assign lt = occupied && (key < ctrl.key);

  // The first cell that does not stay ahead takes the new entry; the cells
  // after it move one place toward the tail.
  always_comb begin
    key_next = key;
    tag_next = tag;
    if (ctrl.push) begin
      if (!lt) begin
        if (left_lt) begin
          key_next = ctrl.key;
          tag_next = ctrl.tag;
        end else begin
          key_next = left_key;
          tag_next = left_tag;
        end
      end
    end else if (ctrl.pop) begin
      key_next = right_key;
      tag_next = right_tag;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    tag <= tag_next;
  end

endmodule

// ----- src/sorted_priority_queue_top.sv -----
// ---------------------------------------------------------------------------
// Sorted priority queue
// Bounded min-priority queue held in key order in a chain of cells.
// ---------------------------------------------------------------------------
// Usage:
// Requests arrive on req: push stores key and tag ahead of the first entry
// whose key is greater than or equal, pop returns the smallest entry, clear
// empties the queue. Every request gives exactly one result on rsp with the
// popped entry, a status code and the entry count after the operation.
// A pop on an empty queue reports empty; a push on a full queue reports full
// and drops the entry.
// The result is registered in the cycle after its request. One request is
// taken per cycle while the receiver does not stall: all cells compare the new
// key and shift in parallel, so the chain settles in the same cycle as the request.
// The result sits in an output register. When the receiver stalls, the
// result holds and req.ready drops until it is taken; a request is taken in
// the same cycle as the previous result leaves.
// Reset empties the queue and drops any pending result; the cell contents
// need no reset since only cells below the count are ever read.
// ---------------------------------------------------------------------------
module sorted_priority_queue_top import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic                  accept;
  logic                  full;
  logic                  empty;
  rsp_t                  result;
  cell_ctrl_t            ctrl;

  logic [CAPACITY-1:0]   occupied;
  logic [CAPACITY-1:0]   lt;
  logic [CAPACITY-1:0]   left_lt;
  logic [KEY_BITS-1:0]   cell_key [CAPACITY];
  logic [TAG_BITS-1:0]   cell_tag [CAPACITY];
  logic [KEY_BITS-1:0]   left_key [CAPACITY];
  logic [TAG_BITS-1:0]   left_tag [CAPACITY];
  logic [KEY_BITS-1:0]   right_key [CAPACITY];
  logic [TAG_BITS-1:0]   right_tag [CAPACITY];

  // The output register frees up in the cycle its result is taken.
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == COUNT_BITS'(CAPACITY));
  assign empty     = (count == '0);

  // Broadcast to the chain.
  assign ctrl.push = accept && (req.data.operation == OP_PUSH) && !full;
  assign ctrl.pop  = accept && (req.data.operation == OP_POP) && !empty;
  assign ctrl.key  = req.data.key;
  assign ctrl.tag  = req.data.tag;

  // Neighbor wiring of the chain, with the head and tail ends tied off.
  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      assign occupied[i] = (COUNT_BITS'(i) < count);

      if (i == 0) begin : g_head
        assign left_lt[i]  = 1'b1;
        assign left_key[i] = '0;
        assign left_tag[i] = '0;
      end else begin : g_inner_left
        assign left_lt[i]  = lt[i-1];
        assign left_key[i] = cell_key[i-1];
        assign left_tag[i] = cell_tag[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign right_key[i] = '0;
        assign right_tag[i] = '0;
      end else begin : g_inner_right
        assign right_key[i] = cell_key[i+1];
        assign right_tag[i] = cell_tag[i+1];
      end

      spq_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occupied  (occupied[i]),
        .left_lt   (left_lt[i]),
        .left_key  (left_key[i]),
        .left_tag  (left_tag[i]),
        .right_key (right_key[i]),
        .right_tag (right_tag[i]),
        .lt        (lt[i]),
        .key       (cell_key[i]),
        .tag       (cell_tag[i])
      );
    end
  endgenerate

  // Result and new count for the request taken this cycle.
  always_comb begin
    count_next          = count;
    result.popped_valid = 1'b0;
    result.popped_key   = '0;
    result.popped_tag   = '0;
    result.status       = ST_OK;
    case (req.data.operation)
      OP_PUSH: begin
        if (full) begin
          result.status = ST_FULL;
        end else begin
          count_next = count + COUNT_BITS'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          result.status = ST_EMPTY;
        end else begin
          result.popped_valid = 1'b1;
          result.popped_key   = cell_key[0];
          result.popped_tag   = cell_tag[0];
          count_next          = count - COUNT_BITS'(1);
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
    result.entry_count = count_next;
  end

  // Count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.data <= result;
    end
  end

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(CAPACITY))
    else $error("entry count above capacity");

  // A pending result always reports the current count.
  a_count_report: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.data.entry_count == count))
    else $error("reported entry count differs from held count");

  // A push taken while full is reported as dropped and leaves the count.
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.data.operation == OP_PUSH) && full)
      |=> (rsp.data.status == ST_FULL) && (count == COUNT_BITS'(CAPACITY)))
    else $error("push on full queue not reported as dropped");

  // A returned entry always comes with an ok status.
  a_pop_status: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.popped_valid) |-> (rsp.data.status == ST_OK))
    else $error("popped entry with error status");

endmodule

// ----- sim/tb_sorted_priority_queue_top.sv -----
// ---------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives push, pop, clear and unused requests into the queue and predicts
// every result with a software copy of the sorted list. A short directed part
// covers the field extremes, equal keys, pop when empty, push when full and
// the unused code; random phases follow with sender and receiver idling.
// ---------------------------------------------------------------------------
module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  // Unused operation code; the queue must leave its state as it is.
  localparam logic [OP_BITS-1:0] OP_NONE = 2'd3;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int ITEMS_PER_PH = 362;

  // Software copy of the queue plus the list of results still owed.
  class pq_scoreboard;
    logic [KEY_BITS-1:0] model_key [CAPACITY];
    logic [TAG_BITS-1:0] model_tag [CAPACITY];
    int unsigned held;
    rsp_t owed_rsps [$];
    int unsigned errors;
    int unsigned requests;
    int unsigned results;
    int unsigned hits;
    int unsigned empties;
    int unsigned drops;

    function new();
      held     = 0;
      errors   = 0;
      requests = 0;
      results  = 0;
      hits     = 0;
      empties  = 0;
      drops    = 0;
    endfunction

    // Apply one accepted request to the copy and record the result it owes.
    function void note_request(req_t r);
      rsp_t        want;
      int unsigned pos;
      int unsigned i;
      want = '0;
      requests++;
      case (r.operation)
        OP_PUSH: begin
          if (held >= CAPACITY) begin
            want.status = ST_FULL;
          end else begin
            // New entry goes ahead of the first key that is not smaller.
            pos = 0;
            while (pos < held && model_key[pos] < r.key) pos++;
            for (i = held; i > pos; i--) begin
              model_key[i] = model_key[i-1];
              model_tag[i] = model_tag[i-1];
            end
            model_key[pos] = r.key;
            model_tag[pos] = r.tag;
            held++;
          end
        end
        OP_POP: begin
          if (held == 0) begin
            want.status = ST_EMPTY;
          end else begin
            want.popped_valid = 1'b1;
            want.popped_key   = model_key[0];
            want.popped_tag   = model_tag[0];
            for (i = 1; i < held; i++) begin
              model_key[i-1] = model_key[i];
              model_tag[i-1] = model_tag[i];
            end
            held--;
          end
        end
        OP_CLEAR: begin
          held = 0;
        end
        default: begin
        end
      endcase
      want.entry_count = COUNT_BITS'(held);
      owed_rsps.push_back(want);
    endfunction

    // Compare one accepted result with the oldest owed one.
    function void check_response(rsp_t got);
      rsp_t want;
      results++;
      if (owed_rsps.size() == 0) begin
        $error("unexpected result with no request pending: %h", got);
        errors++;
      end else begin
        want = owed_rsps.pop_front();
        if (want.popped_valid) hits++;
        if (want.status == ST_EMPTY) empties++;
        if (want.status == ST_FULL) drops++;
        if (got.popped_valid !== want.popped_valid) begin
          $error("popped_valid expected %0d got %0d", want.popped_valid, got.popped_valid);
          errors++;
        end
        if (got.popped_key !== want.popped_key) begin
          $error("popped_key expected %h got %h", want.popped_key, got.popped_key);
          errors++;
        end
        if (got.popped_tag !== want.popped_tag) begin
          $error("popped_tag expected %h got %h", want.popped_tag, got.popped_tag);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, got.status);
          errors++;
        end
        if (got.entry_count !== want.entry_count) begin
          $error("entry_count expected %0d got %0d", want.entry_count, got.entry_count);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   cycle_count;

  pq_scoreboard sb;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_priority_queue_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  // Free-running clock, period 8.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Receiver side: ready changes on the falling edge at the stall rate and
  // stays low during reset.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Handshakes are sampled at the rising edge, before the queue updates.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
      if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.data);
    end
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_sorted_priority_queue_top: FAIL");
    $finish;
  end

  // Offer one request, idling first at the sender rate, and hold it until
  // it is taken. Called and returning at a falling edge.
  task automatic send_request(input logic [OP_BITS-1:0] op,
                              input logic [KEY_BITS-1:0] k,
                              input logic [TAG_BITS-1:0] t);
    req_t r;
    r.operation = op;
    r.key       = k;
    r.tag       = t;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Random traffic in bursts that lean toward filling, draining or neither,
  // so the queue keeps passing through both full and empty.
  task automatic run_random_phase(input int n_items, input int idle_pct, input int stall_pct);
    int                  push_pct;
    int                  pick;
    logic [OP_BITS-1:0]  op;
    logic [KEY_BITS-1:0] k;
    push_pct       = 50;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < n_items; n++) begin
      if (n % 24 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 75;
          1:       push_pct = 25;
          default: push_pct = 50;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) op = OP_CLEAR;
      else if (pick < 4) op = OP_NONE;
      else if ($urandom_range(0, 99) < push_pct) op = OP_PUSH;
      else op = OP_POP;
      // Keys cluster on a few small values now and then to force ties.
      case ($urandom_range(0, 9))
        0:       k = '0;
        1:       k = '1;
        2, 3, 4: k = KEY_BITS'($urandom_range(0, 7));
        default: k = KEY_BITS'($urandom);
      endcase
      send_request(op, k, TAG_BITS'($urandom));
    end
  endtask

  initial begin
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.data    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sb             = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: pop when empty, the unused code, then a full queue with
    // extreme and equal keys, a push when full, pops, clear and empty again.
    send_request(OP_POP, 16'hffff, 16'hffff);
    send_request(OP_NONE, 16'hffff, 16'hffff);
    for (int i = 0; i < CAPACITY; i++) begin
      case (i)
        0:       send_request(OP_PUSH, 16'hffff, 16'h0000);
        1:       send_request(OP_PUSH, 16'h0000, 16'hffff);
        2:       send_request(OP_PUSH, 16'h8000, 16'haaaa);
        3:       send_request(OP_PUSH, 16'h8000, 16'h5555);
        default: send_request(OP_PUSH, KEY_BITS'(i * 16'h1111), TAG_BITS'(i));
      endcase
    end
    send_request(OP_PUSH, 16'h0001, 16'h1234);
    send_request(OP_NONE, 16'h0000, 16'h0000);
    send_request(OP_POP, 16'h0000, 16'h0000);
    send_request(OP_POP, 16'h0000, 16'h0000);
    send_request(OP_POP, 16'h0000, 16'h0000);
    send_request(OP_CLEAR, 16'hffff, 16'hffff);
    send_request(OP_POP, 16'h0000, 16'h0000);

    // Random phases: no idling, slow sender, slow receiver, both mildly.
    run_random_phase(ITEMS_PER_PH, 0, 0);
    run_random_phase(ITEMS_PER_PH, 87, 0);
    run_random_phase(ITEMS_PER_PH, 0, 87);
    run_random_phase(ITEMS_PER_PH, 18, 18);
    req_ch.valid <= 1'b0;

    // Drain, then give any stray result time to show up.
    while (sb.owed_rsps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d requests and %0d results in %0d cycles.",
             sb.requests, sb.results, cycle_count);
    $display("Pops returning an entry: %0d, pops on empty: %0d, pushes dropped when full: %0d.",
             sb.hits, sb.empties, sb.drops);
    if (sb.errors == 0 && sb.owed_rsps.size() == 0) begin
      $display("tb_sorted_priority_queue_top: PASS");
    end else begin
      $display("tb_sorted_priority_queue_top: FAIL");
    end
    $finish;
  end

endmodule
